/* rtl/core/lrufr_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrufr_pkg
// Request codes and fixed word layouts for the LRU frame replacer.
// ----------------------------------------------------------------------------
package lrufr_pkg;

  localparam int REQ_W       = 2;
  localparam int FRAME_NUM_W = 4;
  localparam int COUNT_W     = 5;

  localparam logic [REQ_W-1:0] OP_VICTIM = 2'd0;
  localparam logic [REQ_W-1:0] OP_PIN    = 2'd1;
  localparam logic [REQ_W-1:0] OP_UNPIN  = 2'd2;

  // Input word: req_type, frame_num.
  localparam int IN_DATA_W  = 8;
  // Output word: victim_valid, victim_frame, evictable_count.
  localparam int OUT_DATA_W = 16;

  typedef struct packed {
    logic                   victim_valid;
    logic [FRAME_NUM_W-1:0] victim_frame;
    logic [COUNT_W-1:0]     evictable_count;
  } result_t;

endpackage

/* rtl/core/lrufr_link_mem.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lrufr_link_mem
// Forward and backward link memories of the replacement order, indexed by
// frame number, each with one write port and a registered read port.
// ----------------------------------------------------------------------------
module lrufr_link_mem #(
  parameter int DEPTH = 16,
  parameter int AW    = 4
) (
  input  logic          clk,
  input  logic          rd_en,
  input  logic [AW-1:0] rd_addr,
  output logic [AW-1:0] rd_next,
  output logic [AW-1:0] rd_prev,
  input  logic          next_wr_en,
  input  logic [AW-1:0] next_wr_addr,
  input  logic [AW-1:0] next_wr_data,
  input  logic          prev_wr_en,
  input  logic [AW-1:0] prev_wr_addr,
  input  logic [AW-1:0] prev_wr_data
);

  logic [AW-1:0] next_mem [DEPTH];
  logic [AW-1:0] prev_mem [DEPTH];

  always_ff @(posedge clk) begin
    if (next_wr_en) begin
      next_mem[next_wr_addr] <= next_wr_data;
    end
    if (rd_en) begin
      rd_next <= next_mem[rd_addr];
    end
  end

  always_ff @(posedge clk) begin
    if (prev_wr_en) begin
      prev_mem[prev_wr_addr] <= prev_wr_data;
    end
    if (rd_en) begin
      rd_prev <= prev_mem[rd_addr];
    end
  end

endmodule

/* rtl/core/lru_frame_replacer_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// lru_frame_replacer_unit
// Tracks evictable buffer-pool frames in unpin order as a linked list held in
// two link memories, with head, tail, count and per-frame held bits in
// registers.
//
//   Channel  Dir  Carries
//   s_axis   in   one request word per handshake
//   m_axis   out  one result word per request
//
// For each request, the accept edge reads the frame's links (or the head's
// links for a victim); the commit edge, which a held result can delay, writes
// back the relinked neighbours and loads the result register.
// Reset clears head, tail, count and the held bits at once; the link
// memories need no clearing.
// A waiting result does not stop the next request from being accepted; the
// block only stalls when a new result is ready and the old one is still held.
// ----------------------------------------------------------------------------
module lru_frame_replacer_unit
  import lrufr_pkg::*;
#(
  parameter int FRAMES = 16
) (
  input  logic                  clk,
  input  logic                  rst,
  input  logic                  s_axis_tvalid,
  output logic                  s_axis_tready,
  // [1:0] req_type, [5:2] frame_num, [7:6] zero
  input  logic [IN_DATA_W-1:0]  s_axis_tdata,
  output logic                  m_axis_tvalid,
  input  logic                  m_axis_tready,
  // [0] victim_valid, [4:1] victim_frame, [9:5] evictable_count, [15:10] zero
  output logic [OUT_DATA_W-1:0] m_axis_tdata
);

  localparam int FW = (FRAMES > 1) ? $clog2(FRAMES) : 1;
  localparam int CW = $clog2(FRAMES + 1);
  localparam logic [CW-1:0] FULL = CW'(FRAMES);

  localparam logic ST_IDLE = 1'b0;
  localparam logic ST_EXEC = 1'b1;

  logic                   state;
  logic [FW-1:0]          head;
  logic [FW-1:0]          tail;
  logic [CW-1:0]          held;
  logic [FRAMES-1:0]      used;
  logic [REQ_W-1:0]       op;
  logic [FW-1:0]          fr;
  logic                   fr_ok;

  logic [FW-1:0]          head_next;
  logic [FW-1:0]          tail_next;
  logic [CW-1:0]          held_next;
  logic [FRAMES-1:0]      used_next;
  result_t                res;

  logic                   s_accept;
  logic                   commit;
  logic [REQ_W-1:0]       in_op;
  logic [FRAME_NUM_W-1:0] in_frame;
  logic [FW-1:0]          in_idx;

  logic [FW-1:0]          rd_next;
  logic [FW-1:0]          rd_prev;
  logic                   next_wr_en;
  logic [FW-1:0]          next_wr_addr;
  logic [FW-1:0]          next_wr_data;
  logic                   prev_wr_en;
  logic [FW-1:0]          prev_wr_addr;
  logic [FW-1:0]          prev_wr_data;

  assign in_op    = s_axis_tdata[REQ_W-1:0];
  assign in_frame = s_axis_tdata[REQ_W+FRAME_NUM_W-1:REQ_W];
  assign in_idx   = FW'(in_frame);

  assign s_axis_tready = (state == ST_IDLE);
  assign s_accept      = s_axis_tvalid && s_axis_tready;
  assign commit        = (state == ST_EXEC) && (!m_axis_tvalid || m_axis_tready);

  lrufr_link_mem #(
    .DEPTH (FRAMES),
    .AW    (FW)
  ) u_link_mem (
    .clk          (clk),
    .rd_en        (s_accept),
    .rd_addr      ((in_op == OP_VICTIM) ? head : in_idx),
    .rd_next      (rd_next),
    .rd_prev      (rd_prev),
    .next_wr_en   (next_wr_en),
    .next_wr_addr (next_wr_addr),
    .next_wr_data (next_wr_data),
    .prev_wr_en   (prev_wr_en),
    .prev_wr_addr (prev_wr_addr),
    .prev_wr_data (prev_wr_data)
  );

  // Relinking. The stale backward link of the head and the forward link of
  // the tail are never followed, since head and tail are compared directly.
  always_comb begin
    head_next    = head;
    tail_next    = tail;
    held_next    = held;
    used_next    = used;
    next_wr_en   = 1'b0;
    next_wr_addr = rd_prev;
    next_wr_data = rd_next;
    prev_wr_en   = 1'b0;
    prev_wr_addr = rd_next;
    prev_wr_data = rd_prev;
    res          = '0;
    unique case (op)
      OP_VICTIM: begin
        if (held != '0) begin
          res.victim_valid = 1'b1;
          res.victim_frame = FRAME_NUM_W'(head);
          used_next[head]  = 1'b0;
          head_next        = rd_next;
          held_next        = held - CW'(1);
        end
      end
      OP_PIN: begin
        if (fr_ok && used[fr]) begin
          used_next[fr] = 1'b0;
          held_next     = held - CW'(1);
          if (fr == head && fr == tail) begin
            head_next = head;
          end else if (fr == head) begin
            head_next = rd_next;
          end else if (fr == tail) begin
            tail_next = rd_prev;
          end else begin
            next_wr_en = commit;
            prev_wr_en = commit;
          end
        end
      end
      OP_UNPIN: begin
        if (fr_ok && !used[fr] && held < FULL) begin
          used_next[fr] = 1'b1;
          held_next     = held + CW'(1);
          tail_next     = fr;
          if (held == '0) begin
            head_next = fr;
          end else begin
            next_wr_en   = commit;
            next_wr_addr = tail;
            next_wr_data = fr;
            prev_wr_en   = commit;
            prev_wr_addr = fr;
            prev_wr_data = tail;
          end
        end
      end
      default: begin
        res = '0;
      end
    endcase
    res.evictable_count = COUNT_W'(held_next);
  end

  always_ff @(posedge clk) begin
    if (s_accept) begin
      op    <= in_op;
      fr    <= in_idx;
      fr_ok <= (32'(in_frame) < FRAMES);
    end
    if (commit) begin
      m_axis_tdata <= OUT_DATA_W'({res.evictable_count, res.victim_frame,
                                   res.victim_valid});
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state         <= ST_IDLE;
      head          <= '0;
      tail          <= '0;
      held          <= '0;
      used          <= '0;
      m_axis_tvalid <= 1'b0;
    end else begin
      if (s_accept) begin
        state <= ST_EXEC;
      end else if (commit) begin
        state <= ST_IDLE;
      end
      if (commit) begin
        head          <= head_next;
        tail          <= tail_next;
        held          <= held_next;
        used          <= used_next;
        m_axis_tvalid <= 1'b1;
      end else if (m_axis_tready) begin
        m_axis_tvalid <= 1'b0;
      end
    end
  end

  a_accept_to_exec: assert property (@(posedge clk) disable iff (rst)
    s_accept |=> state == ST_EXEC)
    else $error("accepted request did not move to the execute cycle");

  a_count_matches_used: assert property (@(posedge clk) disable iff (rst)
    32'(held) == $countones(used))
    else $error("held count disagrees with the held bits");

  a_result_from_exec: assert property (@(posedge clk) disable iff (rst)
    $rose(m_axis_tvalid) |-> $past(state) == ST_EXEC)
    else $error("result word appeared without an execute cycle");

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the LRU frame replacer. A short table of directed
// requests covers the empty order, pin and unpin corner cases and the
// reserved request code. A long run of random request words follows, shaped
// in phases that fill or drain the order. Every result word is compared field
// by field with a typed expectation or a behavioural model of the unpin order.
// ----------------------------------------------------------------------------
module testbench
  import lrufr_pkg::*;
;

  localparam int FRAMES          = 16;
  localparam int RANDOM_REQUESTS = 1250;
  localparam int CALM_TAIL       = 150;
  localparam int STALL_LIMIT     = 1000;
  localparam int DRAIN_CYCLES    = 20;
  localparam int MAX_REPORTS     = 40;

  // Request code that the block must treat as a no-op.
  localparam logic [REQ_W-1:0] OP_RESERVED = 2'd3;

  typedef struct packed {
    logic [REQ_W-1:0]       op;
    logic [FRAME_NUM_W-1:0] frame;
    logic                   typed;
    result_t                want;
  } stim_row_t;

  logic                  clk           = 1'b0;
  logic                  rst           = 1'b1;
  logic                  s_axis_tvalid = 1'b0;
  logic                  s_axis_tready;
  logic [IN_DATA_W-1:0]  s_axis_tdata  = '0;
  logic                  m_axis_tvalid;
  logic                  m_axis_tready = 1'b0;
  logic [OUT_DATA_W-1:0] m_axis_tdata;

  // Model state: frames in unpin order, oldest first, and their held bits.
  logic [FRAME_NUM_W-1:0] lru_order[$];
  logic [FRAMES-1:0]      frame_held = '0;

  result_t   pending_results[$];
  stim_row_t directed_rows[$];

  int mismatches      = 0;
  int results_seen    = 0;
  int quiet_cycles    = 0;
  int src_gap_pct     = 0;
  int sink_stall_pct  = 0;
  int sink_stall_left = 0;

  lru_frame_replacer_unit #(
    .FRAMES(FRAMES)
  ) u_top (
    .clk          (clk),
    .rst          (rst),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata)
  );

  initial begin
    forever #1 clk = ~clk;
  end

  // Applies one request to the model and returns the result word it expects.
  function automatic result_t replace_step(input logic [REQ_W-1:0] op,
                                           input logic [FRAME_NUM_W-1:0] frame);
    result_t r;
    int      pos;
    r   = '0;
    pos = -1;
    case (op)
      OP_VICTIM: begin
        if (lru_order.size() > 0) begin
          r.victim_valid = 1'b1;
          r.victim_frame = lru_order[0];
          lru_order.delete(0);
          frame_held[r.victim_frame] = 1'b0;
        end
      end
      OP_PIN: begin
        if (frame_held[frame]) begin
          foreach (lru_order[k]) begin
            if (pos < 0 && lru_order[k] == frame) pos = k;
          end
          if (pos >= 0) lru_order.delete(pos);
          frame_held[frame] = 1'b0;
        end
      end
      OP_UNPIN: begin
        if (!frame_held[frame] && lru_order.size() < FRAMES) begin
          lru_order = {lru_order, frame};
          frame_held[frame] = 1'b1;
        end
      end
      default: begin
      end
    endcase
    r.evictable_count = COUNT_W'(lru_order.size());
    return r;
  endfunction

  task automatic report_mismatch(input string what, input int got, input int want);
    mismatches++;
    if (mismatches <= MAX_REPORTS)
      $display("mismatch on result %0d: %s got %0d expected %0d", results_seen, what,
               got, want);
  endtask

  task automatic add_row(input logic [REQ_W-1:0] op, input logic [FRAME_NUM_W-1:0] frame,
                         input logic typed, input logic vv,
                         input logic [FRAME_NUM_W-1:0] vf, input logic [COUNT_W-1:0] cnt);
    stim_row_t row;
    row.op                   = op;
    row.frame                = frame;
    row.typed                = typed;
    row.want.victim_valid    = vv;
    row.want.victim_frame    = vf;
    row.want.evictable_count = cnt;
    directed_rows = {directed_rows, row};
  endtask

  // Offers one request word, holds it until accepted, then records the
  // expected result. A typed expectation replaces the model's answer.
  task automatic send_request(input logic [REQ_W-1:0] op,
                              input logic [FRAME_NUM_W-1:0] frame,
                              input logic typed, input result_t want);
    result_t predicted;
    if ($urandom_range(0, 99) < src_gap_pct) begin
      s_axis_tvalid <= 1'b0;
      repeat ($urandom_range(1, 9)) @(posedge clk);
    end
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= {{(IN_DATA_W - REQ_W - FRAME_NUM_W){1'b0}}, frame, op};
    do @(posedge clk); while (!s_axis_tready);
    predicted = replace_step(op, frame);
    pending_results = {pending_results, (typed ? want : predicted)};
  endtask

  // Result sink with random stall bursts.
  always @(posedge clk) begin
    if (sink_stall_left > 0) begin
      sink_stall_left <= sink_stall_left - 1;
      m_axis_tready   <= 1'b0;
    end else if ($urandom_range(0, 99) < sink_stall_pct) begin
      sink_stall_left <= $urandom_range(0, 8);
      m_axis_tready   <= 1'b0;
    end else begin
      m_axis_tready <= 1'b1;
    end
  end

  // Result checking and the watchdog on cycles with no word accepted.
  always @(posedge clk) begin : check_results
    result_t want;
    if (!rst && m_axis_tvalid && m_axis_tready) begin
      if (pending_results.size() == 0) begin
        report_mismatch("result word with nothing expected", 32'(m_axis_tdata), 0);
      end else begin
        want = pending_results[0];
        pending_results.delete(0);
        if (m_axis_tdata[0] !== want.victim_valid)
          report_mismatch("victim_valid", 32'(m_axis_tdata[0]), 32'(want.victim_valid));
        if (m_axis_tdata[4:1] !== want.victim_frame)
          report_mismatch("victim_frame", 32'(m_axis_tdata[4:1]),
                          32'(want.victim_frame));
        if (m_axis_tdata[9:5] !== want.evictable_count)
          report_mismatch("evictable_count", 32'(m_axis_tdata[9:5]),
                          32'(want.evictable_count));
        if (m_axis_tdata[15:10] !== '0)
          report_mismatch("padding bits", 32'(m_axis_tdata[15:10]), 0);
      end
      results_seen++;
    end
    if ((m_axis_tvalid && m_axis_tready) || (s_axis_tvalid && s_axis_tready))
      quiet_cycles = 0;
    else
      quiet_cycles++;
    if (quiet_cycles >= STALL_LIMIT) begin
      $display("FAIL");
      $finish;
    end
  end

  initial begin : stimulus
    int                     seg_left;
    int                     unpin_pct;
    int                     pin_pct;
    int                     pick;
    logic [REQ_W-1:0]       op;
    logic [FRAME_NUM_W-1:0] frame;

    // Directed table: expected words are typed in where they are obvious.
    add_row(OP_VICTIM,   4'd0,  1'b1, 1'b0, 4'd0, 5'd0);  // victim on an empty order
    add_row(OP_RESERVED, 4'd15, 1'b1, 1'b0, 4'd0, 5'd0);
    add_row(OP_PIN,      4'd7,  1'b1, 1'b0, 4'd0, 5'd0);  // pin of a frame not held
    add_row(OP_UNPIN,    4'd0,  1'b1, 1'b0, 4'd0, 5'd1);
    add_row(OP_UNPIN,    4'd15, 1'b1, 1'b0, 4'd0, 5'd2);
    add_row(OP_UNPIN,    4'd0,  1'b1, 1'b0, 4'd0, 5'd2);  // already held, keeps its place
    add_row(OP_UNPIN,    4'd9,  1'b1, 1'b0, 4'd0, 5'd3);
    add_row(OP_PIN,      4'd15, 1'b1, 1'b0, 4'd0, 5'd2);  // removal from the middle
    add_row(OP_VICTIM,   4'd15, 1'b1, 1'b1, 4'd0, 5'd1);
    add_row(OP_RESERVED, 4'd0,  1'b1, 1'b0, 4'd0, 5'd1);
    add_row(OP_VICTIM,   4'd0,  1'b1, 1'b1, 4'd9, 5'd0);
    add_row(OP_VICTIM,   4'd0,  1'b1, 1'b0, 4'd0, 5'd0);
    add_row(OP_UNPIN,    4'd3,  1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_UNPIN,    4'd5,  1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_UNPIN,    4'd10, 1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_UNPIN,    4'd12, 1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_UNPIN,    4'd6,  1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_PIN,      4'd3,  1'b0, 1'b0, 4'd0, 5'd0);  // pin the oldest frame
    add_row(OP_PIN,      4'd6,  1'b0, 1'b0, 4'd0, 5'd0);  // pin the newest frame
    add_row(OP_VICTIM,   4'd15, 1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_PIN,      4'd10, 1'b0, 1'b0, 4'd0, 5'd0);
    add_row(OP_VICTIM,   4'd0,  1'b0, 1'b0, 4'd0, 5'd0);

    repeat (8) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    src_gap_pct    = 25;
    sink_stall_pct = 25;
    foreach (directed_rows[r])
      send_request(directed_rows[r].op, directed_rows[r].frame, directed_rows[r].typed,
                   directed_rows[r].want);

    // Random phases alternate between filling, draining and a plain mix so
    // that both the full and the empty order are reached many times.
    seg_left  = 0;
    unpin_pct = 40;
    pin_pct   = 25;
    for (int n = 0; n < RANDOM_REQUESTS; n++) begin
      if (seg_left == 0) begin
        seg_left = $urandom_range(20, 60);
        case ($urandom_range(0, 2))
          0:       begin unpin_pct = 65; pin_pct = 10; end
          1:       begin unpin_pct = 25; pin_pct = 35; end
          default: begin unpin_pct = 40; pin_pct = 25; end
        endcase
        case ($urandom_range(0, 2))
          0:       src_gap_pct = 0;
          1:       src_gap_pct = 15;
          default: src_gap_pct = 40;
        endcase
        case ($urandom_range(0, 2))
          0:       sink_stall_pct = 0;
          1:       sink_stall_pct = 15;
          default: sink_stall_pct = 40;
        endcase
      end
      seg_left--;
      if (n >= RANDOM_REQUESTS - CALM_TAIL) begin
        src_gap_pct    = 0;
        sink_stall_pct = 0;
      end

      pick = $urandom_range(0, 99);
      if (pick < 4)
        op = OP_RESERVED;
      else if (pick < 4 + unpin_pct)
        op = OP_UNPIN;
      else if (pick < 4 + unpin_pct + pin_pct)
        op = OP_PIN;
      else
        op = OP_VICTIM;

      // Most pins name a frame that is actually held.
      if (op == OP_PIN && lru_order.size() > 0 && $urandom_range(0, 3) != 0)
        frame = lru_order[$urandom_range(0, lru_order.size() - 1)];
      else
        frame = FRAME_NUM_W'($urandom_range(0, FRAMES - 1));

      send_request(op, frame, 1'b0, '0);
    end
    s_axis_tvalid <= 1'b0;

    while (pending_results.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);

    if (mismatches == 0)
      $display("PASS");
    else
      $display("FAIL");
    $finish;
  end

endmodule
